/* rtl/clt_pkg.sv */
// ----------------------------------------------------------------------------
// clt_pkg
// Shared word types, token codes and keyword table of the token lexer.
// ----------------------------------------------------------------------------
package clt_pkg;

	localparam logic KIND_CHAR  = 1'b0;
	localparam logic KIND_TOKEN = 1'b1;

	localparam logic [5:0] TK_PLUS   = 6'd0;
	localparam logic [5:0] TK_MINUS  = 6'd1;
	localparam logic [5:0] TK_STAR   = 6'd2;
	localparam logic [5:0] TK_SLASH  = 6'd3;
	localparam logic [5:0] TK_LT     = 6'd4;
	localparam logic [5:0] TK_LE     = 6'd5;
	localparam logic [5:0] TK_SHL    = 6'd6;
	localparam logic [5:0] TK_GT     = 6'd7;
	localparam logic [5:0] TK_GE     = 6'd8;
	localparam logic [5:0] TK_SHR    = 6'd9;
	localparam logic [5:0] TK_ASSIGN = 6'd10;
	localparam logic [5:0] TK_EQ     = 6'd11;
	localparam logic [5:0] TK_NE     = 6'd12;
	localparam logic [5:0] TK_SEMI   = 6'd13;
	localparam logic [5:0] TK_LPAREN = 6'd14;
	localparam logic [5:0] TK_RPAREN = 6'd15;
	localparam logic [5:0] TK_DOT    = 6'd16;
	localparam logic [5:0] TK_COMMA  = 6'd17;
	localparam logic [5:0] TK_LBRACE = 6'd18;
	localparam logic [5:0] TK_RBRACE = 6'd19;
	localparam logic [5:0] TK_INTLIT = 6'd20;
	localparam logic [5:0] TK_FLOAT  = 6'd21;
	localparam logic [5:0] TK_STRLIT = 6'd22;
	localparam logic [5:0] TK_IDENT  = 6'd23;
	localparam logic [5:0] TK_KW0    = 6'd24;
	localparam logic [5:0] TK_EOF    = 6'd34;
	localparam logic [5:0] TK_ERROR  = 6'd35;

	localparam int KW_COUNT = 10;
	localparam logic [2:0] PREFIX_LEN = 3'd6;
	localparam logic [2:0] LEN_OVER   = 3'd7;

	localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
		{"int", 24'h0}, "double", {"else", 16'h0}, {"if", 32'h0}, "return",
		"string", {"auto", 16'h0}, {"cin", 24'h0}, {"for", 24'h0}, {"cout", 16'h0}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd3, 3'd6, 3'd4, 3'd2, 3'd6, 3'd6, 3'd4, 3'd3, 3'd3, 3'd4
	};

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_file;
	} in_word_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] lexeme_char;
		logic [5:0] token_code;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] lexeme_char;
		logic [5:0] token_code;
	} res_t;

	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} bundle_t;

endpackage

/* rtl/clt_front.sv */
// ----------------------------------------------------------------------------
// clt_front
// Lexer state machine: takes one byte word per cycle unless the queue is full
// and forms the bundle of up to two results, with the closing-byte re-scan.
// ----------------------------------------------------------------------------
module clt_front
	import clt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  in_word_t byte_word,
	input  logic     full,
	output logic     push,
	output bundle_t  bundle
);

	typedef enum logic [4:0] {
		S_START, S_WORD, S_INT, S_FRAC, S_EXP, S_EXP1, S_EXP2,
		S_STR, S_ESC, S_HEX1, S_HEX2, S_BANG, S_EQ, S_LT, S_GT,
		S_SLASH, S_LCOM, S_BCOM, S_BSTAR
	} lex_state_t;

	lex_state_t state_q;
	logic [2:0] len_q;
	logic [7:0] prefix_q [6];

	function automatic res_t mk_char(input logic [7:0] c);
		mk_char = '{result_kind: KIND_CHAR, lexeme_char: c, token_code: 6'd0};
	endfunction

	function automatic res_t mk_tok(input logic [5:0] t);
		mk_tok = '{result_kind: KIND_TOKEN, lexeme_char: 8'd0, token_code: t};
	endfunction

	logic [7:0] c;
	logic       eof, nx;
	logic       is_digit, is_alpha, is_hex, is_space, is_word, is_e;
	logic       accept;

	logic [5:0] word_tok;
	logic       hit;

	logic       st_n, st_fresh;
	res_t       st_res;
	lex_state_t st_next;

	logic [1:0] pre_n;
	res_t       pre_r0, pre_r1;
	lex_state_t pre_next;
	logic       go_start, cont_add;

	logic [1:0] n_res;
	lex_state_t next_state;
	logic       fresh_add, add_en;
	logic [2:0] word_idx;

	assign c        = byte_word.ch;
	assign eof      = byte_word.end_of_file;
	assign nx       = !eof;
	assign is_digit = (c >= "0") && (c <= "9");
	assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign is_hex   = is_digit || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
	assign is_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	assign is_word  = is_alpha || is_digit || (c == "_");
	assign is_e     = (c == "e") || (c == "E");
	assign accept   = byte_valid && !full;
	assign byte_stall = full;

	always_comb begin
		word_tok = TK_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			hit = (KW_LEN[k] == len_q);
			for (int j = 0; j < 6; j++) begin
				if ((3'(j) < KW_LEN[k]) && (prefix_q[j] != KW_TEXT[k][47 - 8 * j -: 8]))
					hit = 1'b0;
			end
			if (hit)
				word_tok = TK_KW0 + 6'(k);
		end
	end

	always_comb begin
		st_n     = 1'b0;
		st_res   = mk_char(c);
		st_next  = S_START;
		st_fresh = 1'b0;
		if (eof) begin
			st_n   = 1'b1;
			st_res = mk_tok(TK_EOF);
		end else if (is_space) begin
			st_n = 1'b0;
		end else if (is_alpha || (c == "_")) begin
			st_n     = 1'b1;
			st_next  = S_WORD;
			st_fresh = 1'b1;
		end else if (is_digit) begin
			st_n    = 1'b1;
			st_next = S_INT;
		end else begin
			unique case (c)
				"\"": st_next = S_STR;
				"/":  st_next = S_SLASH;
				"<":  st_next = S_LT;
				">":  st_next = S_GT;
				"=":  st_next = S_EQ;
				"!":  st_next = S_BANG;
				"+": begin st_n = 1'b1; st_res = mk_tok(TK_PLUS); end
				"-": begin st_n = 1'b1; st_res = mk_tok(TK_MINUS); end
				"*": begin st_n = 1'b1; st_res = mk_tok(TK_STAR); end
				";": begin st_n = 1'b1; st_res = mk_tok(TK_SEMI); end
				"(": begin st_n = 1'b1; st_res = mk_tok(TK_LPAREN); end
				")": begin st_n = 1'b1; st_res = mk_tok(TK_RPAREN); end
				".": begin st_n = 1'b1; st_res = mk_tok(TK_DOT); end
				",": begin st_n = 1'b1; st_res = mk_tok(TK_COMMA); end
				"{": begin st_n = 1'b1; st_res = mk_tok(TK_LBRACE); end
				"}": begin st_n = 1'b1; st_res = mk_tok(TK_RBRACE); end
				default: st_n = 1'b0;
			endcase
		end
	end

	always_comb begin
		pre_n    = 2'd0;
		pre_r0   = mk_char(c);
		pre_r1   = mk_char(c);
		pre_next = S_START;
		go_start = 1'b0;
		cont_add = 1'b0;
		unique case (state_q)
			S_START: go_start = 1'b1;
			S_WORD: begin
				pre_n = 2'd1;
				if (nx && is_word) begin
					cont_add = 1'b1;
					pre_next = S_WORD;
				end else begin
					pre_r0   = mk_tok(word_tok);
					go_start = 1'b1;
				end
			end
			S_INT: begin
				pre_n = 2'd1;
				if (nx && is_digit) pre_next = S_INT;
				else if (nx && (c == ".")) pre_next = S_FRAC;
				else if (nx && is_e) pre_next = S_EXP;
				else begin
					pre_r0   = mk_tok(TK_INTLIT);
					go_start = 1'b1;
				end
			end
			S_FRAC: begin
				pre_n = 2'd1;
				if (nx && is_digit) pre_next = S_FRAC;
				else if (nx && is_e) pre_next = S_EXP;
				else begin
					pre_r0   = mk_tok(TK_FLOAT);
					go_start = 1'b1;
				end
			end
			S_EXP: begin
				pre_n = 2'd1;
				if (nx && (is_digit || (c == "+") || (c == "-"))) pre_next = S_EXP1;
				else begin
					pre_r0   = mk_tok(TK_ERROR);
					go_start = 1'b1;
				end
			end
			S_EXP1: begin
				pre_n = 2'd1;
				if (nx && is_digit) pre_next = S_EXP2;
				else begin
					pre_r0   = mk_tok(TK_ERROR);
					go_start = 1'b1;
				end
			end
			S_EXP2: begin
				pre_n = 2'd1;
				if (nx && is_digit) pre_next = S_EXP2;
				else begin
					go_start = 1'b1;
					if (nx && ((c == " ") || (c == ";") || (c == ")") || (c == "+") ||
						(c == "-") || (c == "/") || (c == "*")))
						pre_r0 = mk_tok(TK_FLOAT);
					else
						pre_r0 = mk_tok(TK_ERROR);
				end
			end
			S_STR: begin
				if (eof) begin
					pre_n = 2'd1; pre_r0 = mk_tok(TK_ERROR); go_start = 1'b1;
				end else if (c == "\"") begin
					pre_n = 2'd1; pre_r0 = mk_tok(TK_STRLIT);
				end else if (c == "\\") begin
					pre_next = S_ESC;
				end else if (c > 8'd31) begin
					pre_n = 2'd1; pre_next = S_STR;
				end else begin
					pre_n = 2'd1; pre_r0 = mk_tok(TK_ERROR); go_start = 1'b1;
				end
			end
			S_ESC: begin
				pre_next = S_STR;
				if (eof) begin
					pre_n = 2'd1; pre_r0 = mk_tok(TK_ERROR); go_start = 1'b1;
					pre_next = S_START;
				end else if (c == "n") begin
					pre_n = 2'd1; pre_r0 = mk_char(8'd10);
				end else if (c == "\\") begin
					pre_n = 2'd1; pre_r0 = mk_char(8'd92);
				end else if (c == "t") begin
					pre_n = 2'd1; pre_r0 = mk_char(8'd9);
				end else if (c == "\"") begin
					pre_n = 2'd0;
				end else if (c == "x") begin
					pre_n = 2'd2; pre_r0 = mk_char(8'd92); pre_next = S_HEX1;
				end else begin
					pre_n = 2'd1; pre_r0 = mk_tok(TK_ERROR); go_start = 1'b1;
					pre_next = S_START;
				end
			end
			S_HEX1, S_HEX2: begin
				pre_n = 2'd1;
				if (nx && is_hex) pre_next = (state_q == S_HEX1) ? S_HEX2 : S_STR;
				else begin
					pre_r0   = mk_tok(TK_ERROR);
					go_start = 1'b1;
				end
			end
			S_BANG: begin
				pre_n = 2'd1;
				if (nx && (c == "=")) pre_r0 = mk_tok(TK_NE);
				else begin
					pre_r0   = mk_tok(TK_ERROR);
					go_start = 1'b1;
				end
			end
			S_EQ: begin
				pre_n = 2'd1;
				if (nx && (c == "=")) pre_r0 = mk_tok(TK_EQ);
				else begin
					pre_r0   = mk_tok(TK_ASSIGN);
					go_start = 1'b1;
				end
			end
			S_LT: begin
				pre_n = 2'd1;
				if (nx && (c == "=")) pre_r0 = mk_tok(TK_LE);
				else if (nx && (c == "<")) pre_r0 = mk_tok(TK_SHL);
				else begin
					pre_r0   = mk_tok(TK_LT);
					go_start = 1'b1;
				end
			end
			S_GT: begin
				pre_n = 2'd1;
				if (nx && (c == "=")) pre_r0 = mk_tok(TK_GE);
				else if (nx && (c == ">")) pre_r0 = mk_tok(TK_SHR);
				else begin
					pre_r0   = mk_tok(TK_GT);
					go_start = 1'b1;
				end
			end
			S_SLASH: begin
				if (nx && (c == "/")) pre_next = S_LCOM;
				else if (nx && (c == "*")) pre_next = S_BCOM;
				else begin
					pre_n    = 2'd1;
					pre_r0   = mk_tok(TK_SLASH);
					go_start = 1'b1;
				end
			end
			S_LCOM: begin
				if (eof) begin
					pre_n = 2'd1; pre_r0 = mk_tok(TK_EOF);
				end else if (c != 8'h0A) begin
					pre_next = S_LCOM;
				end
			end
			S_BCOM: begin
				if (eof) begin
					pre_n = 2'd1; pre_r0 = mk_tok(TK_EOF);
				end else begin
					pre_next = (c == "*") ? S_BSTAR : S_BCOM;
				end
			end
			S_BSTAR: begin
				if (eof) begin
					pre_n = 2'd1; pre_r0 = mk_tok(TK_EOF);
				end else if (c == "*") begin
					pre_next = S_BSTAR;
				end else if (c != "/") begin
					pre_next = S_BCOM;
				end
			end
			default: go_start = 1'b1;
		endcase
	end

	always_comb begin
		bundle = '{two: 1'b0, r0: pre_r0, r1: pre_r1};
		if (go_start) begin
			next_state = st_next;
			n_res      = pre_n + {1'b0, st_n};
			if (pre_n != 2'd0) begin
				bundle.r1 = st_res;
			end else begin
				bundle.r0 = st_res;
			end
		end else begin
			next_state = pre_next;
			n_res      = pre_n;
		end
		bundle.two = (n_res == 2'd2);
	end

	assign push      = accept && (n_res != 2'd0);
	assign fresh_add = go_start && st_fresh;
	assign add_en    = accept && (cont_add || fresh_add);
	assign word_idx  = fresh_add ? 3'd0 : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			len_q   <= 3'd0;
		end else if (accept) begin
			state_q <= next_state;
			if (add_en) begin
				if (fresh_add)
					len_q <= 3'd1;
				else if (len_q < LEN_OVER)
					len_q <= len_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_en && (word_idx < PREFIX_LEN))
			prefix_q[word_idx] <= c;
	end

endmodule

/* rtl/clt_fifo.sv */
// ----------------------------------------------------------------------------
// clt_fifo
// Short bundle queue between the lexer state machine and the result sender.
// ----------------------------------------------------------------------------
module clt_fifo
	import clt_pkg::*;
#(
	parameter int Depth = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wr_data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output bundle_t head
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	bundle_t         mem_q [Depth];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(Depth));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		bump = (p == AW'(Depth - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("bundle written into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("bundle taken from an empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(Depth))
		else $error("queue count beyond depth");

endmodule

/* rtl/clt_back.sv */
// ----------------------------------------------------------------------------
// clt_back
// Result sender: splits each queued bundle into one or two result words and
// holds each in the output register until it is taken.
// ----------------------------------------------------------------------------
module clt_back
	import clt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      empty,
	input  bundle_t   head,
	output logic      pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result_word
);

	logic      valid_q;
	logic      sel_q;
	out_word_t out_q;
	logic      load;
	logic      fin;
	res_t      pick;

	assign load = (!valid_q || !result_stall) && !empty;
	assign pick = sel_q ? head.r1 : head.r0;
	assign fin  = sel_q || !head.two;
	assign pop  = load && fin;

	assign result_valid = valid_q;
	assign result_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= !fin;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			out_q <= '{result_kind: pick.result_kind, lexeme_char: pick.lexeme_char,
				token_code: pick.token_code, last: fin};
	end

	a_second_half: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (!empty && head.two))
		else $error("second result selected without a two-result bundle");

	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sel_q) |-> (valid_q && !out_q.last))
		else $error("second result pending after a final word");

endmodule

/* rtl/c_like_token_lexer_core.sv */
// ----------------------------------------------------------------------------
// c_like_token_lexer_core
// Token lexer for a small C-like language, one source byte per word.
// ----------------------------------------------------------------------------
// One byte word (or end-of-file mark) is taken per cycle while the bundle
// queue has room. Each byte gives zero, one or two result words: lexeme
// characters as they are appended and token codes as tokens close; a byte
// that closes a token is rescanned from the start state in the same cycle.
// Results leave one per cycle through a registered output while result_stall
// is low, so a byte with two results holds the output longer than a byte
// with one; the single result port sets the sustained rate, and the
// queue of QueueDepth bundles absorbs bursts. The first result word of a
// byte passes through the bundle queue and then the output register.
// ----------------------------------------------------------------------------
module c_like_token_lexer_core
	import clt_pkg::*;
#(
	parameter int QueueDepth = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_word_t  byte_word,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result_word
);

	logic    push, full, pop, empty;
	bundle_t wr_bundle, head;

	clt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_word  (byte_word),
		.full       (full),
		.push       (push),
		.bundle     (wr_bundle)
	);

	clt_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	clt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word)
	);

endmodule
